// ===== hw/rtl/srtt_pkg.sv =====
// shared types and constants of the state residency and transition tracker
// no dependencies
`default_nettype none
package srtt_pkg;
	localparam int ID_W   = 4;
	localparam int TIME_W = 32;
	localparam int CNT_W  = 16;
	localparam int FILL_W = 5;
	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [ID_W-1:0]  from_id;
		logic [ID_W-1:0]  to_id;
		logic [CNT_W-1:0] count;
	} pair_t;

	typedef struct packed {
		logic load_in;
		logic start_only;
		logic res_rd;
		logic res_wr;
		logic scan_start;
		logic scan_step;
		logic hit_wr;
		logic miss_wr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic start_zero;
		logic differs;
		logic do_trans;
		logic scan_hit;
		logic scan_done;
		logic out_free;
	} sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/state_residency_transition_tracker_unit.sv =====
// top level of the state residency and transition tracker
// depends on srtt_pkg, srtt_ctrl, srtt_dp
//
// input channel in_valid/in_ready carries one word: time_ms and emotion_id.
// output channel out_valid/out_ready returns one result word per input word.
// a word is taken at a clock edge with valid and ready both high.
// one word is worked on at a time; in_ready is high while the unit is idle.
// a start or an unchanged state passes decode and finish; a change also reads
// and writes the residency store; a change that counts a transition then scans
// the transition table, reading one entry per cycle from a single memory port,
// and writes the hit or miss entry. the next word can be taken in the cycle
// after the result is loaded.
// the result sits in an output register, so the next word is taken while a
// result waits; a stalled receiver holds the unit only when a second result
// is ready to be written.
// asynchronous reset clears start time, current and previous state, history
// and table counters and the residency valid bits; no clearing pass is run.
`default_nettype none
module state_residency_transition_tracker_unit import srtt_pkg::*; #(
	parameter int NUM_STATES         = 16,
	parameter int HISTORY_DEPTH      = 16,
	parameter int TRANSITION_ENTRIES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [TIME_W-1:0] time_ms,
	input  wire logic [ID_W-1:0]   emotion_id,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   started,
	output logic                   changed,
	output logic [TIME_W-1:0]      dwell_ms,
	output logic [ID_W-1:0]        left_state,
	output logic [TIME_W-1:0]      left_total_ms,
	output logic                   history_pushed,
	output logic [FILL_W-1:0]      history_fill,
	output logic                   transition_noted,
	output logic [CNT_W-1:0]       transition_count,
	output logic                   transition_evicted
);
	cmd_t cmd;
	sts_t sts;

	srtt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sts(sts), .cmd(cmd)
	);

	srtt_dp #(
		.NUM_STATES(NUM_STATES), .HISTORY_DEPTH(HISTORY_DEPTH),
		.TRANSITION_ENTRIES(TRANSITION_ENTRIES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.time_ms(time_ms), .emotion_id(emotion_id),
		.out_valid(out_valid), .out_ready(out_ready),
		.started(started), .changed(changed), .dwell_ms(dwell_ms),
		.left_state(left_state), .left_total_ms(left_total_ms),
		.history_pushed(history_pushed), .history_fill(history_fill),
		.transition_noted(transition_noted), .transition_count(transition_count),
		.transition_evicted(transition_evicted)
	);
endmodule
`default_nettype wire

// ===== hw/rtl/srtt_ctrl.sv =====
// controller state machine of the tracker
// depends on srtt_pkg
`default_nettype none
module srtt_ctrl import srtt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  sts_t      sts,
	output cmd_t      cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_ACC  = 3'd2;
	localparam logic [2:0] S_SRCH = 3'd3;
	localparam logic [2:0] S_HIT  = 3'd4;
	localparam logic [2:0] S_MISS = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				if (sts.start_zero) begin
					cmd.start_only = 1'b1;
					state_d = S_FIN;
				end else if (sts.differs) begin
					cmd.res_rd = 1'b1;
					state_d = S_ACC;
				end else begin
					state_d = S_FIN;
				end
			end
			S_ACC: begin
				cmd.res_wr = 1'b1;
				if (sts.do_trans) begin
					cmd.scan_start = 1'b1;
					state_d = S_SRCH;
				end else begin
					state_d = S_FIN;
				end
			end
			S_SRCH: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_hit) state_d = S_HIT;
				else if (sts.scan_done) state_d = S_MISS;
			end
			S_HIT: begin
				cmd.hit_wr = 1'b1;
				state_d = S_FIN;
			end
			S_MISS: begin
				cmd.miss_wr = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

// ===== hw/rtl/srtt_dp.sv =====
// datapath of the tracker: state registers, residency store, transition table, result word
// depends on srtt_pkg
`default_nettype none
module srtt_dp import srtt_pkg::*; #(
	parameter int NUM_STATES         = 16,
	parameter int HISTORY_DEPTH      = 16,
	parameter int TRANSITION_ENTRIES = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	input  wire logic [TIME_W-1:0] time_ms,
	input  wire logic [ID_W-1:0]   emotion_id,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   started,
	output logic                   changed,
	output logic [TIME_W-1:0]      dwell_ms,
	output logic [ID_W-1:0]        left_state,
	output logic [TIME_W-1:0]      left_total_ms,
	output logic                   history_pushed,
	output logic [FILL_W-1:0]      history_fill,
	output logic                   transition_noted,
	output logic [CNT_W-1:0]       transition_count,
	output logic                   transition_evicted
);
	localparam int SW = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
	localparam int HW = $clog2(HISTORY_DEPTH + 1);
	localparam int TW = $clog2(TRANSITION_ENTRIES);
	localparam int UW = $clog2(TRANSITION_ENTRIES + 1);

	logic [TIME_W-1:0] start_q, time_q;
	logic [ID_W-1:0]   cur_q, prev_q, id_q, newest_q, key_q;
	logic [HW-1:0]     hcnt_q;
	logic [UW-1:0]     used_q, issued_q;
	logic [TW-1:0]     oldest_q, ptr_q, rd_addr_q;
	logic              pend_q, ovld_q;

	logic [TIME_W-1:0] res_mem [NUM_STATES];
	logic [NUM_STATES-1:0] res_vld_q;
	logic [TIME_W-1:0] res_rd_q;
	logic              res_rd_vld_q;

	pair_t tbl_mem [TRANSITION_ENTRIES];
	pair_t tbl_rd_q;

	logic              r_started_q, r_changed_q, r_pushed_q, r_noted_q, r_evict_q;
	logic [TIME_W-1:0] r_dwell_q, r_total_q;
	logic [ID_W-1:0]   r_left_q;
	logic [CNT_W-1:0]  r_count_q;

	logic [SW-1:0]     cur_idx;
	logic              cur_in_range;
	logic [TIME_W-1:0] dwell, res_sum;
	logic              push;
	logic              issue;
	logic [TW-1:0]     ptr_nxt, oldest_nxt, miss_slot;
	logic [UW:0]       slot_sum;
	logic              tbl_full;
	logic [CNT_W-1:0]  cnt_inc;
	logic              tbl_we;
	logic [TW-1:0]     tbl_wa;
	pair_t             tbl_wd;

	assign cur_idx      = SW'(cur_q);
	assign cur_in_range = (32'(cur_q) < NUM_STATES);
	assign dwell        = (time_q >= start_q) ? (time_q - start_q) : '0;
	assign res_sum      = (res_rd_vld_q ? res_rd_q : '0) + dwell;
	assign push         = !((hcnt_q != '0) && (newest_q == id_q));

	assign sts.start_zero = (start_q == '0);
	assign sts.differs    = (id_q != cur_q);
	assign sts.do_trans   = (id_q != '0) && (prev_q != '0) && (prev_q != id_q);
	assign sts.scan_hit   = pend_q && (tbl_rd_q.from_id == key_q) && (tbl_rd_q.to_id == id_q);
	assign sts.scan_done  = !pend_q && (issued_q == used_q);
	assign sts.out_free   = !ovld_q || out_ready;

	assign issue   = cmd.scan_step && !sts.scan_hit && (issued_q != used_q);
	assign ptr_nxt = (32'(ptr_q) == TRANSITION_ENTRIES - 1) ? '0 : ptr_q + 1'b1;
	assign oldest_nxt = (32'(oldest_q) == TRANSITION_ENTRIES - 1) ? '0 : oldest_q + 1'b1;
	assign slot_sum = {1'b0, UW'(oldest_q)} + {1'b0, used_q};
	assign miss_slot = (32'(slot_sum) >= TRANSITION_ENTRIES)
		? TW'(32'(slot_sum) - TRANSITION_ENTRIES) : TW'(slot_sum);
	assign tbl_full = (32'(used_q) == TRANSITION_ENTRIES);
	assign cnt_inc  = (tbl_rd_q.count == CNT_MAX) ? tbl_rd_q.count : tbl_rd_q.count + 1'b1;

	always_comb begin
		tbl_we = cmd.hit_wr || cmd.miss_wr;
		tbl_wa = rd_addr_q;
		tbl_wd = '{from_id: key_q, to_id: id_q, count: cnt_inc};
		if (cmd.miss_wr) begin
			tbl_wa = tbl_full ? oldest_q : miss_slot;
			tbl_wd.count = CNT_W'(1);
		end
	end

	// residency store
	always_ff @(posedge clk) begin
		if (cmd.res_wr && cur_in_range) res_mem[cur_idx] <= res_sum;
		if (cmd.res_rd) res_rd_q <= res_mem[cur_idx];
	end

	// transition table
	always_ff @(posedge clk) begin
		if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
		if (issue) tbl_rd_q <= tbl_mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			time_q <= time_ms;
			id_q <= emotion_id;
			r_started_q <= 1'b0;
			r_changed_q <= 1'b0;
			r_dwell_q <= '0;
			r_left_q <= '0;
			r_total_q <= '0;
			r_pushed_q <= 1'b0;
			r_noted_q <= 1'b0;
			r_count_q <= '0;
			r_evict_q <= 1'b0;
		end
		if (cmd.start_only) r_started_q <= 1'b1;
		if (cmd.res_rd) res_rd_vld_q <= res_vld_q[cur_idx] && cur_in_range;
		if (cmd.res_wr) begin
			r_changed_q <= 1'b1;
			r_dwell_q <= dwell;
			r_left_q <= cur_q;
			r_total_q <= cur_in_range ? res_sum : '0;
			r_pushed_q <= (id_q != '0) && push;
			key_q <= prev_q;
		end
		if (issue) rd_addr_q <= ptr_q;
		if (cmd.hit_wr) begin
			r_noted_q <= 1'b1;
			r_count_q <= cnt_inc;
		end
		if (cmd.miss_wr) begin
			r_noted_q <= 1'b1;
			r_count_q <= CNT_W'(1);
			r_evict_q <= tbl_full;
		end
		if (cmd.out_load) begin
			started <= r_started_q;
			changed <= r_changed_q;
			dwell_ms <= r_dwell_q;
			left_state <= r_left_q;
			left_total_ms <= r_total_q;
			history_pushed <= r_pushed_q;
			history_fill <= FILL_W'(hcnt_q);
			transition_noted <= r_noted_q;
			transition_count <= r_count_q;
			transition_evicted <= r_evict_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			cur_q <= '0;
			prev_q <= '0;
			newest_q <= '0;
			hcnt_q <= '0;
			used_q <= '0;
			oldest_q <= '0;
			issued_q <= '0;
			ptr_q <= '0;
			pend_q <= 1'b0;
			res_vld_q <= '0;
			ovld_q <= 1'b0;
		end else begin
			if (cmd.start_only) begin
				start_q <= time_q;
				cur_q <= id_q;
			end
			if (cmd.res_wr) begin
				start_q <= time_q;
				cur_q <= id_q;
				if (cur_in_range) res_vld_q[cur_idx] <= 1'b1;
				if (id_q != '0) begin
					prev_q <= id_q;
					if (push) begin
						newest_q <= id_q;
						if (32'(hcnt_q) < HISTORY_DEPTH) hcnt_q <= hcnt_q + 1'b1;
					end
				end
			end
			if (cmd.scan_start) begin
				ptr_q <= oldest_q;
				issued_q <= '0;
				pend_q <= 1'b0;
			end else if (cmd.scan_step) begin
				pend_q <= issue;
				if (issue) begin
					ptr_q <= ptr_nxt;
					issued_q <= issued_q + 1'b1;
				end
			end
			if (cmd.miss_wr) begin
				if (tbl_full) oldest_q <= oldest_nxt;
				else used_q <= used_q + 1'b1;
			end
			if (cmd.out_load) ovld_q <= 1'b1;
			else if (out_ready) ovld_q <= 1'b0;
		end
	end

	assign out_valid = ovld_q;
endmodule
`default_nettype wire
